// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MTDM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MTDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mtdm_pkg.sv =====
// Types and constants of the threshold dwell monitor.
package mtdm_pkg;

	localparam int NUM_CH  = 4;
	localparam int VAL_W   = 16;
	localparam int DIST_W  = 16;
	localparam int SCORE_W = 17;
	localparam int SUM_W   = 19;
	localparam int CNT_W   = 3;
	localparam int TS_W    = 32;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 3;
	localparam int RECIP_W = 18;
	localparam int PROD_W  = SUM_W + RECIP_W;

	localparam logic [SCORE_W-1:0] SCORE_FULL = 17'd65536;
	// ceil(2^19 / 3); exact floor division by three for sums below 2^19.
	localparam logic [RECIP_W-1:0] RECIP3 = 18'd174763;
	localparam int RECIP_SHIFT = 19;

	localparam logic [1:0] ST_PROGRESS = 2'd0;
	localparam logic [1:0] ST_ACTIVE   = 2'd1;
	localparam logic [1:0] ST_MISSING  = 2'd2;

	localparam logic [IDX_W-1:0] REG_THRESH = 3'd0;
	localparam logic [IDX_W-1:0] REG_BANDS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DIR    = 3'd2;
	localparam logic [IDX_W-1:0] REG_COUNT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DWELL  = 3'd4;

	localparam logic [CFG_W-1:0] BANDS_RESET = 64'h0001_0001_0001_0001;

	typedef struct packed {
		logic [NUM_CH-1:0][VAL_W-1:0] thresh;
		logic [NUM_CH-1:0][VAL_W-1:0] bands;
		logic [NUM_CH-1:0]            dir;
		logic [CNT_W-1:0]             count;
		logic [TS_W-1:0]              dwell;
	} cfg_t;

	typedef struct packed {
		logic                          missing;
		logic [NUM_CH-1:0]             used;
		logic [NUM_CH-1:0]             full_sc;
		logic [NUM_CH-1:0]             div_go;
		logic [NUM_CH-1:0][DIST_W-1:0] dev;
		logic [NUM_CH-1:0][DIST_W-1:0] band;
		logic [CNT_W-1:0]              cnt;
		logic [TS_W-1:0]               ts;
	} entry_t;

endpackage

// ===== hw/rtl/multi_channel_threshold_dwell_monitor_core.sv =====
// Top level of the multi-channel threshold dwell monitor.
//
//  channel   handshake        payload
//  input     push / full      sample_0..sample_3, present_mask, timestamp
//  result    empty / pop      status, progress
//  config    cfg_write        cfg_index, cfg_data
//
// A snapshot with all channels in use present passes through the back part in
// order: it is taken from the queue, the per-channel restoring dividers run (one
// quotient bit per cycle, then a registered done flag), then sum, multiply for
// the mean, and finish.
// A snapshot with a missing sample skips to finish. A two-entry queue takes new
// requests while the back part works, and a held result stalls only the back part.
// Reset clears the queues, the dwell time stamp and the registers to their defaults.
module multi_channel_threshold_dwell_monitor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [mtdm_pkg::VAL_W-1:0] sample_0,
	input  logic signed [mtdm_pkg::VAL_W-1:0] sample_1,
	input  logic signed [mtdm_pkg::VAL_W-1:0] sample_2,
	input  logic signed [mtdm_pkg::VAL_W-1:0] sample_3,
	input  logic [mtdm_pkg::NUM_CH-1:0]       present_mask,
	input  logic [mtdm_pkg::TS_W-1:0]         timestamp,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        status,
	output logic [mtdm_pkg::SCORE_W-1:0]      progress,
	input  logic                              cfg_write,
	input  logic [mtdm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [mtdm_pkg::CFG_W-1:0]        cfg_data
);
	import mtdm_pkg::*;
`include "assert_macros.svh"

	cfg_t                          cfg_q;
	logic [NUM_CH-1:0][VAL_W-1:0]  samples;
	entry_t                        front_entry;
	entry_t                        q_head;
	logic                          q_empty;
	logic                          q_pop;

	assign samples = {sample_3, sample_2, sample_1, sample_0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thresh <= '0;
			cfg_q.bands  <= BANDS_RESET;
			cfg_q.dir    <= '0;
			cfg_q.count  <= CNT_W'(1);
			cfg_q.dwell  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESH: cfg_q.thresh <= cfg_data;
				REG_BANDS:  cfg_q.bands  <= cfg_data;
				REG_DIR:    cfg_q.dir    <= cfg_data[NUM_CH-1:0];
				REG_COUNT:  cfg_q.count  <= cfg_data[CNT_W-1:0];
				REG_DWELL:  cfg_q.dwell  <= cfg_data[TS_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	mtdm_front u_front (
		.cfg     (cfg_q),
		.samples (samples),
		.present (present_mask),
		.ts      (timestamp),
		.entry   (front_entry)
	);

	mtdm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_entry),
		.full    (full),
		.pop     (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	mtdm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.status   (status),
		.progress (progress)
	);

	`MTDM_ASSERT_NOW(a_active_full, !empty && status == ST_ACTIVE, progress == SCORE_FULL, "activation without full progress")
	`MTDM_ASSERT_NOW(a_missing_zero, !empty && status == ST_MISSING, progress == '0, "missing sample with nonzero progress")
	`MTDM_ASSERT_NOW(a_progress_max, !empty, progress <= SCORE_FULL && status <= ST_MISSING, "result out of range")
	`MTDM_ASSERT_NEXT(a_push_queued, push && !full, !q_empty || !empty, "accepted request vanished")
endmodule

// ===== hw/rtl/mtdm_fifo.sv =====
// Two-entry queue of classified requests between the front and back parts.
module mtdm_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mtdm_pkg::entry_t wr_data,
	output logic             full,
	input  logic             pop,
	output mtdm_pkg::entry_t rd_data,
	output logic             empty
);
	import mtdm_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hw/rtl/mtdm_front.sv =====
// Front part: checks presence and classifies each channel of a snapshot.
module mtdm_front (
	input  mtdm_pkg::cfg_t                                        cfg,
	input  logic [mtdm_pkg::NUM_CH-1:0][mtdm_pkg::VAL_W-1:0]      samples,
	input  logic [mtdm_pkg::NUM_CH-1:0]                           present,
	input  logic [mtdm_pkg::TS_W-1:0]                             ts,
	output mtdm_pkg::entry_t                                      entry
);
	import mtdm_pkg::*;

	logic [CNT_W-1:0]      cnt;
	logic signed [VAL_W:0] diff [NUM_CH];
	logic [VAL_W:0]        mag  [NUM_CH];
	logic [NUM_CH-1:0]     met;

	always_comb begin
		cnt = cfg.count;
		if (cnt == '0) begin
			cnt = CNT_W'(1);
		end else if (cnt > CNT_W'(NUM_CH)) begin
			cnt = CNT_W'(NUM_CH);
		end
	end

	always_comb begin
		entry.cnt = cnt;
		entry.ts  = ts;
		for (int i = 0; i < NUM_CH; i++) begin
			diff[i] = $signed({samples[i][VAL_W-1], samples[i]})
				- $signed({cfg.thresh[i][VAL_W-1], cfg.thresh[i]});
			mag[i]  = $unsigned(diff[i][VAL_W] ? -diff[i] : diff[i]);
			// Direction bit set: met strictly below the threshold.
			met[i]  = cfg.dir[i] ? diff[i][VAL_W] : !diff[i][VAL_W];
			entry.used[i]    = (CNT_W'(i) < cnt);
			entry.dev[i]     = mag[i][DIST_W-1:0];
			entry.band[i]    = (cfg.bands[i] == '0) ? DIST_W'(1) : cfg.bands[i];
			entry.full_sc[i] = entry.used[i] && met[i];
			entry.div_go[i]  = entry.used[i] && !met[i]
				&& (entry.dev[i] < entry.band[i]);
		end
		entry.missing = |(entry.used & ~present);
	end
endmodule

// ===== hw/rtl/mtdm_div.sv =====
// Restoring divider for one channel: floor(dev * 2^16 / band), dev below band.
module mtdm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mtdm_pkg::DIST_W-1:0]   dev,
	input  logic [mtdm_pkg::DIST_W-1:0]   band,
	output logic [mtdm_pkg::DIST_W-1:0]   quot,
	output logic                          done
);
	import mtdm_pkg::*;

	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] band_q;
	logic [DIST_W-1:0] quot_q;
	logic [3:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIST_W:0]   rem2;
	logic              fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = (rem2 >= {1'b0, band_q});
	assign quot = quot_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			band_q <= '0;
			quot_q <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= dev;
			band_q <= band;
			quot_q <= '0;
			step_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= fits ? DIST_W'(rem2 - {1'b0, band_q}) : rem2[DIST_W-1:0];
			quot_q <= {quot_q[DIST_W-2:0], fits};
			step_q <= step_q + 4'd1;
			if (step_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end
endmodule

// ===== hw/rtl/mtdm_back.sv =====
// Back part: scores channels, forms the mean, tracks dwell and holds the result.
module mtdm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtdm_pkg::cfg_t                cfg,
	input  logic                          q_empty,
	input  mtdm_pkg::entry_t              q_head,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [1:0]                    status,
	output logic [mtdm_pkg::SCORE_W-1:0]  progress
);
	import mtdm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SUM,
		S_MUL,
		S_FIN
	} state_t;

	state_t                     state_q;
	entry_t                     ent_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       all_met_q;
	logic [PROD_W-1:0]          prod_q;
	logic [TS_W-1:0]            last_unmet_q;
	logic                       res_valid_q;
	logic [1:0]                 status_q;
	logic [SCORE_W-1:0]         progress_q;

	logic                       div_start;
	logic [NUM_CH-1:0][DIST_W-1:0] quot;
	logic [NUM_CH-1:0]          done;
	logic [SCORE_W-1:0]         score [NUM_CH];
	logic [NUM_CH-1:0]          lane_full;
	logic [SUM_W-1:0]           sum;
	logic [SCORE_W-1:0]         mean;
	logic [TS_W-1:0]            elapsed;
	logic                       out_free;
	logic                       fin_fire;

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign div_start = q_pop && !q_head.missing;
	assign out_free  = !res_valid_q || pop;
	assign fin_fire  = (state_q == S_FIN) && out_free;
	assign elapsed   = ent_q.ts - last_unmet_q;

	assign empty    = !res_valid_q;
	assign status   = status_q;
	assign progress = progress_q;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		mtdm_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.dev    (q_head.dev[i]),
			.band   (q_head.band[i]),
			.quot   (quot[i]),
			.done   (done[i])
		);
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (ent_q.full_sc[i]) begin
				score[i] = SCORE_FULL;
			end else if (ent_q.div_go[i]) begin
				score[i] = SCORE_FULL - {1'b0, quot[i]};
			end else begin
				score[i] = '0;
			end
			lane_full[i] = (score[i] == SCORE_FULL);
			sum = sum + SUM_W'(score[i]);
		end
	end

	always_comb begin
		case (ent_q.cnt)
			CNT_W'(1): mean = sum_q[SCORE_W-1:0];
			CNT_W'(2): mean = sum_q[SCORE_W:1];
			CNT_W'(3): mean = prod_q[RECIP_SHIFT+SCORE_W-1:RECIP_SHIFT];
			default:   mean = sum_q[SCORE_W+1:2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ent_q        <= '0;
			sum_q        <= '0;
			all_met_q    <= 1'b0;
			prod_q       <= '0;
			last_unmet_q <= '0;
			res_valid_q  <= 1'b0;
			status_q     <= ST_PROGRESS;
			progress_q   <= '0;
		end else begin
			if (fin_fire) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						ent_q   <= q_head;
						state_q <= q_head.missing ? S_FIN : S_DIV;
					end
				end
				S_DIV: begin
					if (&done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q     <= sum;
					all_met_q <= &(lane_full | ~ent_q.used);
					state_q   <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(sum_q) * PROD_W'(RECIP3);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (ent_q.missing) begin
							status_q   <= ST_MISSING;
							progress_q <= '0;
						end else if (all_met_q) begin
							status_q   <= (elapsed >= cfg.dwell) ? ST_ACTIVE : ST_PROGRESS;
							progress_q <= SCORE_FULL;
						end else begin
							// Any channel short of full restarts the dwell window.
							last_unmet_q <= ent_q.ts;
							status_q     <= ST_PROGRESS;
							progress_q   <= mean;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
